### design/fovu_pkg.sv
// shared constants, register codes and angle table of the fov lens remap core
package fovu_pkg;

  localparam int unsigned COORD_BITS_DEF   = 12;
  localparam int unsigned CORDIC_STEPS_DEF = 20;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_COL  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_ROW  = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_X = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_Y = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOV     = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TWICE_TAN   = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_COLS  = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_ROWS  = 4'd7;

  localparam int unsigned CTR_W  = 20;
  localparam int unsigned INVF_W = 25;
  localparam int unsigned IFOV_W = 20;
  localparam int unsigned TT_W   = 22;
  localparam int unsigned IMG_W  = 13;

  localparam logic [CTR_W-1:0]  CENTER_COL_RST  = 20'd81920;
  localparam logic [CTR_W-1:0]  CENTER_ROW_RST  = 20'd61440;
  localparam logic [INVF_W-1:0] INV_FOCAL_RST   = 25'd65536;
  localparam logic [IFOV_W-1:0] INV_FOV_RST     = 20'd65536;
  localparam logic [TT_W-1:0]   TWICE_TAN_RST   = 22'd71608;
  localparam logic [IMG_W-1:0]  IMAGE_COLS_RST  = 13'd640;
  localparam logic [IMG_W-1:0]  IMAGE_ROWS_RST  = 13'd480;

  localparam int unsigned TERM_W = 20;
  localparam int unsigned SUM_W  = 2 * TERM_W + 1;
  localparam int unsigned RAD_W  = TERM_W + 1;
  localparam int unsigned TAN_W  = 27;
  localparam int unsigned ANG_W  = 17;
  localparam int unsigned RD_W   = 21;
  localparam int unsigned SCL_W  = 32;

  function automatic logic [ANG_W-1:0] atan_tab(input int unsigned i);
    logic [ANG_W-1:0] v;
    case (i)
      0:       v = 17'd51472;
      1:       v = 17'd30386;
      2:       v = 17'd16055;
      3:       v = 17'd8150;
      4:       v = 17'd4091;
      5:       v = 17'd2047;
      6:       v = 17'd1024;
      7:       v = 17'd512;
      8:       v = 17'd256;
      9:       v = 17'd128;
      10:      v = 17'd64;
      11:      v = 17'd32;
      12:      v = 17'd16;
      13:      v = 17'd8;
      14:      v = 17'd4;
      15:      v = 17'd2;
      16:      v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### design/fovu_norm.sv
// offset from the principal point, focal normalization and squared radius
module fovu_norm #(
  parameter int unsigned COORD_BITS = fovu_pkg::COORD_BITS_DEF,
  parameter int unsigned AW         = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [COORD_BITS-1:0]         col_i,
  input  logic [COORD_BITS-1:0]         row_i,
  input  logic [fovu_pkg::CTR_W-1:0]    center_col_i,
  input  logic [fovu_pkg::CTR_W-1:0]    center_row_i,
  input  logic [fovu_pkg::INVF_W-1:0]   inv_focal_x_i,
  input  logic [fovu_pkg::INVF_W-1:0]   inv_focal_y_i,
  output logic                          vld_o,
  output logic [fovu_pkg::SUM_W-1:0]    sum_o,
  output logic [2*(AW+1)-1:0]           tag_o
);

  localparam int unsigned PW = AW + fovu_pkg::INVF_W;
  localparam int unsigned TW = fovu_pkg::TERM_W;

  logic [4:0] vld_q;
  logic [2*(AW+1)-1:0] tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [PW-1:0] px_q, py_q;
  logic [TW-1:0] x_q, y_q;
  logic [2*TW-1:0] xx_q, yy_q;
  logic [fovu_pkg::SUM_W-1:0] sum_q;

  logic signed [AW:0] dx, dy;
  logic [AW-1:0] ax, ay;
  logic [PW-17:0] xs, ys;

  always_comb begin
    dx = $signed({{(AW+1-COORD_BITS-8){1'b0}}, col_i, 8'b0})
       - $signed({{(AW+1-fovu_pkg::CTR_W){1'b0}}, center_col_i});
    dy = $signed({{(AW+1-COORD_BITS-8){1'b0}}, row_i, 8'b0})
       - $signed({{(AW+1-fovu_pkg::CTR_W){1'b0}}, center_row_i});
    ax = dx[AW] ? AW'(-dx) : dx[AW-1:0];
    ay = dy[AW] ? AW'(-dy) : dy[AW-1:0];
    xs = px_q[PW-1:16];
    ys = py_q[PW-1:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag1_q <= {dy[AW], ay, dx[AW], ax};
      px_q   <= PW'({{fovu_pkg::INVF_W{1'b0}}, tag1_q[AW-1:0]} * PW'(inv_focal_x_i));
      py_q   <= PW'({{fovu_pkg::INVF_W{1'b0}}, tag1_q[2*AW:AW+1]} * PW'(inv_focal_y_i));
      tag2_q <= tag1_q;
      x_q    <= (|xs[PW-17:TW]) ? {TW{1'b1}} : xs[TW-1:0];
      y_q    <= (|ys[PW-17:TW]) ? {TW{1'b1}} : ys[TW-1:0];
      tag3_q <= tag2_q;
      xx_q   <= {{TW{1'b0}}, x_q} * {{TW{1'b0}}, x_q};
      yy_q   <= {{TW{1'b0}}, y_q} * {{TW{1'b0}}, y_q};
      tag4_q <= tag3_q;
      sum_q  <= {1'b0, xx_q} + {1'b0, yy_q};
      tag5_q <= tag4_q;
    end
  end

  assign vld_o = vld_q[4];
  assign sum_o = sum_q;
  assign tag_o = tag5_q;

endmodule

### design/fovu_sqrt.sv
// pipelined integer square root, one result bit per stage
module fovu_sqrt #(
  parameter int unsigned SW = fovu_pkg::SUM_W,
  parameter int unsigned RW = fovu_pkg::RAD_W,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [SW-1:0] val_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [RW-1:0] root_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q  [RW];
  logic [SW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [TW-1:0] tag_q  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int unsigned B = RW - 1 - j;
    logic          vin;
    logic [SW-1:0] rin;
    logic [RW-1:0] qin;
    logic [TW-1:0] tin;
    logic [SW:0]   trial;
    logic          take;

    if (j == 0) begin : g_first
      assign vin = vld_i;
      assign rin = val_i;
      assign qin = '0;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = vld_q[j-1];
      assign rin = rem_q[j-1];
      assign qin = root_q[j-1];
      assign tin = tag_q[j-1];
    end

    assign trial = ({{(SW+1-RW){1'b0}}, qin} << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign take  = {1'b0, rin} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? SW'({1'b0, rin} - trial) : rin;
        root_q[j] <= take ? (qin | (RW'(1) << B)) : qin;
        tag_q[j]  <= tin;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign tag_o  = tag_q[RW-1];

endmodule

### design/fovu_atan.sv
// tangent argument, pipelined vectoring cordic arctangent and distorted radius
module fovu_atan #(
  parameter int unsigned CORDIC_STEPS = fovu_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned TW           = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [fovu_pkg::RAD_W-1:0]    r_i,
  input  logic [TW-1:0]                 tag_i,
  input  logic [fovu_pkg::TT_W-1:0]     twice_tan_i,
  input  logic [fovu_pkg::IFOV_W-1:0]   inv_fov_i,
  output logic                          vld_o,
  output logic [fovu_pkg::RD_W-1:0]     rd_o,
  output logic [TW-1:0]                 tag_o
);

  localparam int unsigned CW = 32;
  localparam int unsigned ZW = 20;
  localparam int unsigned AN = fovu_pkg::ANG_W;
  localparam int unsigned PW = fovu_pkg::RAD_W + fovu_pkg::TT_W;
  localparam int unsigned MW = AN + fovu_pkg::IFOV_W;

  logic                  t_vld_q;
  logic [fovu_pkg::TAN_W-1:0] t_q;
  logic [TW-1:0]         t_tag_q;
  logic [PW-1:0]         tprod;

  logic                 vld_q [CORDIC_STEPS];
  logic signed [CW-1:0] x_q   [CORDIC_STEPS];
  logic signed [CW-1:0] y_q   [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q   [CORDIC_STEPS];
  logic [TW-1:0]        tag_q [CORDIC_STEPS];

  logic                 rd_vld_q;
  logic [fovu_pkg::RD_W-1:0] rd_q;
  logic [TW-1:0]        rd_tag_q;
  logic [AN-1:0]        ang;
  logic [MW-1:0]        rprod;

  assign tprod = PW'(r_i) * PW'(twice_tan_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else if (en_i) begin
      t_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= tprod[fovu_pkg::TAN_W+15:16];
      t_tag_q <= tag_i;
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
    logic                 vin;
    logic signed [CW-1:0] xin, yin, xs, ys;
    logic signed [ZW-1:0] zin, da;
    logic [TW-1:0]        tin;
    logic                 pos;

    if (j == 0) begin : g_first
      assign vin = t_vld_q;
      assign xin = CW'(65536);
      assign yin = $signed({{(CW-fovu_pkg::TAN_W){1'b0}}, t_q});
      assign zin = '0;
      assign tin = t_tag_q;
    end else begin : g_next
      assign vin = vld_q[j-1];
      assign xin = x_q[j-1];
      assign yin = y_q[j-1];
      assign zin = z_q[j-1];
      assign tin = tag_q[j-1];
    end

    assign xs  = xin >>> j;
    assign ys  = yin >>> j;
    assign pos = !yin[CW-1];
    assign da  = $signed({{(ZW-AN){1'b0}}, fovu_pkg::atan_tab(j)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j]   <= pos ? xin + ys : xin - ys;
        y_q[j]   <= pos ? yin - xs : yin + xs;
        z_q[j]   <= pos ? zin + da : zin - da;
        tag_q[j] <= tin;
      end
    end
  end

  assign ang   = z_q[CORDIC_STEPS-1][ZW-1] ? '0 : z_q[CORDIC_STEPS-1][AN-1:0];
  assign rprod = MW'(ang) * MW'(inv_fov_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (en_i) begin
      rd_vld_q <= vld_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q     <= rprod[MW-1:16];
      rd_tag_q <= tag_q[CORDIC_STEPS-1];
    end
  end

  assign vld_o = rd_vld_q;
  assign rd_o  = rd_q;
  assign tag_o = rd_tag_q;

endmodule

### design/fovu_div.sv
// pipelined restoring divider for the radial scale rd/r, one quotient bit per stage
module fovu_div #(
  parameter int unsigned TW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [fovu_pkg::RD_W-1:0]   rd_i,
  input  logic [fovu_pkg::RAD_W-1:0]  r_i,
  input  logic [TW-1:0]               tag_i,
  output logic                        vld_o,
  output logic [fovu_pkg::SCL_W-1:0]  quo_o,
  output logic                        sat_o,
  output logic                        zero_o,
  output logic [TW-1:0]               tag_o
);

  localparam int unsigned RW = fovu_pkg::RAD_W;
  localparam int unsigned QW = fovu_pkg::SCL_W;

  logic          p_vld_q;
  logic [RW-1:0] p_rem_q, p_r_q;
  logic [QW-1:0] p_nb_q;
  logic          p_sat_q, p_zero_q;
  logic [TW-1:0] p_tag_q;

  logic          vld_q  [QW];
  logic [RW-1:0] rem_q  [QW];
  logic [RW-1:0] r_q    [QW];
  logic [QW-1:0] nb_q   [QW];
  logic [QW-1:0] q_q    [QW];
  logic          sat_q  [QW];
  logic          zero_q [QW];
  logic [TW-1:0] tag_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rem_q  <= RW'(rd_i[fovu_pkg::RD_W-1:8]);
      p_nb_q   <= {rd_i[7:0], 24'b0};
      p_r_q    <= r_i;
      p_sat_q  <= {8'b0, rd_i} >= {r_i, 8'b0};
      p_zero_q <= r_i == '0;
      p_tag_q  <= tag_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          vin, sin, zin, ge;
    logic [RW-1:0] remin, rin;
    logic [QW-1:0] nbin, qin;
    logic [TW-1:0] tin;
    logic [RW:0]   sh;

    if (j == 0) begin : g_first
      assign vin   = p_vld_q;
      assign remin = p_rem_q;
      assign rin   = p_r_q;
      assign nbin  = p_nb_q;
      assign qin   = '0;
      assign sin   = p_sat_q;
      assign zin   = p_zero_q;
      assign tin   = p_tag_q;
    end else begin : g_next
      assign vin   = vld_q[j-1];
      assign remin = rem_q[j-1];
      assign rin   = r_q[j-1];
      assign nbin  = nb_q[j-1];
      assign qin   = q_q[j-1];
      assign sin   = sat_q[j-1];
      assign zin   = zero_q[j-1];
      assign tin   = tag_q[j-1];
    end

    assign sh = {remin, nbin[QW-1]};
    assign ge = sh >= {1'b0, rin};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? RW'(sh - {1'b0, rin}) : sh[RW-1:0];
        r_q[j]    <= rin;
        nb_q[j]   <= {nbin[QW-2:0], 1'b0};
        q_q[j]    <= {qin[QW-2:0], ge};
        sat_q[j]  <= sin;
        zero_q[j] <= zin;
        tag_q[j]  <= tin;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = q_q[QW-1];
  assign sat_o  = sat_q[QW-1];
  assign zero_o = zero_q[QW-1];
  assign tag_o  = tag_q[QW-1];

endmodule

### design/fov_lens_undistort_map_core.sv
// top level of the fov lens remap core: config registers, scaling and bounds test
// throughput: one item per cycle; the whole pipe holds while a result waits untaken
// stages: 5 normalize, 21 square root, CORDIC_STEPS + 2 arctangent, 33 divide, 4 output
// reset: pipeline valid bits cleared, config registers take their reset values
// config port is always ready; writes are meant for an idle pipe
module fov_lens_undistort_map_core #(
  parameter int unsigned COORD_BITS   = fovu_pkg::COORD_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = fovu_pkg::CORDIC_STEPS_DEF,
  localparam int unsigned IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + 8) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [IN_W-1:0]                   s_axis_tdata_i,  // out_col, out_row
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [OUT_W-1:0]                  m_axis_tdata_o,  // src_col, src_row, in_bounds
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fovu_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [fovu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW   = (COORD_BITS + 8 > 20) ? COORD_BITS + 8 : 20;
  localparam int unsigned TGW  = 2 * (AW + 1);
  localparam int unsigned RW   = fovu_pkg::RAD_W;
  localparam int unsigned SW   = fovu_pkg::SCL_W;
  localparam int unsigned OW   = AW + 8;
  localparam int unsigned SCW  = AW + 10;
  localparam int unsigned CPW  = fovu_pkg::TT_W + fovu_pkg::IFOV_W;

  logic [fovu_pkg::CTR_W-1:0]  center_col_q, center_row_q;
  logic [fovu_pkg::INVF_W-1:0] inv_focal_x_q, inv_focal_y_q;
  logic [fovu_pkg::IFOV_W-1:0] inv_fov_q;
  logic [fovu_pkg::TT_W-1:0]   twice_tan_q;
  logic [fovu_pkg::IMG_W-1:0]  image_cols_q, image_rows_q;
  logic [SW-1:0]               s_ctr_q;
  logic [CPW-1:0]              ctr_prod;

  logic en;

  logic              n_vld;
  logic [fovu_pkg::SUM_W-1:0] n_sum;
  logic [TGW-1:0]    n_tag;
  logic              q_vld;
  logic [RW-1:0]     q_root;
  logic [TGW-1:0]    q_tag;
  logic              a_vld;
  logic [fovu_pkg::RD_W-1:0] a_rd;
  logic [RW+TGW-1:0] a_tag;
  logic              d_vld, d_sat, d_zero;
  logic [SW-1:0]     d_quo;
  logic [TGW-1:0]    d_tag;

  logic [2:0]        f_vld_q;
  logic [SW-1:0]     s_q;
  logic [TGW-1:0]    f1_tag_q, f2_tag_q;
  logic [OW-1:0]     ox_q, oy_q;
  logic signed [SCW-1:0] sc_q, sr_q;
  logic [AW+SW-1:0]  px, py;
  logic [AW-1:0]     f_ax, f_ay;
  logic              f_sx, f_sy;
  logic signed [SCW-1:0] ctr_c, ctr_r, off_c, off_r;

  logic [COORD_BITS:0] cols_lim, rows_lim;
  logic                inb;

  logic                  out_vld_q;
  logic [COORD_BITS-1:0] src_col_q, src_row_q;
  logic                  inb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q  <= fovu_pkg::CENTER_COL_RST;
      center_row_q  <= fovu_pkg::CENTER_ROW_RST;
      inv_focal_x_q <= fovu_pkg::INV_FOCAL_RST;
      inv_focal_y_q <= fovu_pkg::INV_FOCAL_RST;
      inv_fov_q     <= fovu_pkg::INV_FOV_RST;
      twice_tan_q   <= fovu_pkg::TWICE_TAN_RST;
      image_cols_q  <= fovu_pkg::IMAGE_COLS_RST;
      image_rows_q  <= fovu_pkg::IMAGE_ROWS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        fovu_pkg::REG_CENTER_COL:  center_col_q  <= cfg_data_i[fovu_pkg::CTR_W-1:0];
        fovu_pkg::REG_CENTER_ROW:  center_row_q  <= cfg_data_i[fovu_pkg::CTR_W-1:0];
        fovu_pkg::REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data_i[fovu_pkg::INVF_W-1:0];
        fovu_pkg::REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data_i[fovu_pkg::INVF_W-1:0];
        fovu_pkg::REG_INV_FOV:     inv_fov_q     <= cfg_data_i[fovu_pkg::IFOV_W-1:0];
        fovu_pkg::REG_TWICE_TAN:   twice_tan_q   <= cfg_data_i[fovu_pkg::TT_W-1:0];
        fovu_pkg::REG_IMAGE_COLS:  image_cols_q  <= cfg_data_i[fovu_pkg::IMG_W-1:0];
        fovu_pkg::REG_IMAGE_ROWS:  image_rows_q  <= cfg_data_i[fovu_pkg::IMG_W-1:0];
        default: ;
      endcase
    end
  end

  // scale limit at the principal point
  assign ctr_prod = CPW'(twice_tan_q) * CPW'(inv_fov_q);

  always_ff @(posedge clk_i) begin
    s_ctr_q <= (|ctr_prod[CPW-1:SW+8]) ? {SW{1'b1}} : ctr_prod[SW+7:8];
  end

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  fovu_norm #(
    .COORD_BITS (COORD_BITS),
    .AW         (AW)
  ) u_norm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (s_axis_tvalid_i),
    .col_i         (s_axis_tdata_i[COORD_BITS-1:0]),
    .row_i         (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .center_col_i  (center_col_q),
    .center_row_i  (center_row_q),
    .inv_focal_x_i (inv_focal_x_q),
    .inv_focal_y_i (inv_focal_y_q),
    .vld_o         (n_vld),
    .sum_o         (n_sum),
    .tag_o         (n_tag)
  );

  fovu_sqrt #(
    .SW (fovu_pkg::SUM_W),
    .RW (RW),
    .TW (TGW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (n_vld),
    .val_i  (n_sum),
    .tag_i  (n_tag),
    .vld_o  (q_vld),
    .root_o (q_root),
    .tag_o  (q_tag)
  );

  fovu_atan #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .TW           (RW + TGW)
  ) u_atan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (q_vld),
    .r_i         (q_root),
    .tag_i       ({q_root, q_tag}),
    .twice_tan_i (twice_tan_q),
    .inv_fov_i   (inv_fov_q),
    .vld_o       (a_vld),
    .rd_o        (a_rd),
    .tag_o       (a_tag)
  );

  fovu_div #(
    .TW (TGW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (a_vld),
    .rd_i   (a_rd),
    .r_i    (a_tag[RW+TGW-1:TGW]),
    .tag_i  (a_tag[TGW-1:0]),
    .vld_o  (d_vld),
    .quo_o  (d_quo),
    .sat_o  (d_sat),
    .zero_o (d_zero),
    .tag_o  (d_tag)
  );

  always_comb begin
    f_ax  = f1_tag_q[AW-1:0];
    f_ay  = f1_tag_q[2*AW:AW+1];
    f_sx  = f2_tag_q[AW];
    f_sy  = f2_tag_q[2*AW+1];
    px    = (AW+SW)'(f_ax) * (AW+SW)'(s_q);
    py    = (AW+SW)'(f_ay) * (AW+SW)'(s_q);
    ctr_c = $signed({{(SCW-fovu_pkg::CTR_W){1'b0}}, center_col_q});
    ctr_r = $signed({{(SCW-fovu_pkg::CTR_W){1'b0}}, center_row_q});
    off_c = $signed({{(SCW-OW){1'b0}}, ox_q});
    off_r = $signed({{(SCW-OW){1'b0}}, oy_q});
    cols_lim = ({3'b0, image_cols_q} > (16'(1) << COORD_BITS))
             ? (COORD_BITS+1)'(1) << COORD_BITS : (COORD_BITS+1)'(image_cols_q);
    rows_lim = ({3'b0, image_rows_q} > (16'(1) << COORD_BITS))
             ? (COORD_BITS+1)'(1) << COORD_BITS : (COORD_BITS+1)'(image_rows_q);
    inb = !sc_q[SCW-1] && !sr_q[SCW-1]
       && (sc_q < $signed({{(SCW-COORD_BITS-9){1'b0}}, cols_lim, 8'b0}))
       && (sr_q < $signed({{(SCW-COORD_BITS-9){1'b0}}, rows_lim, 8'b0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q   <= {f_vld_q[1:0], d_vld};
      out_vld_q <= f_vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q       <= d_zero ? s_ctr_q : (d_sat ? {SW{1'b1}} : d_quo);
      f1_tag_q  <= d_tag;
      ox_q      <= px[AW+SW-1:24];
      oy_q      <= py[AW+SW-1:24];
      f2_tag_q  <= f1_tag_q;
      sc_q      <= f_sx ? ctr_c - off_c : ctr_c + off_c;
      sr_q      <= f_sy ? ctr_r - off_r : ctr_r + off_r;
      src_col_q <= inb ? sc_q[COORD_BITS+7:8] : '0;
      src_row_q <= inb ? sr_q[COORD_BITS+7:8] : '0;
      inb_q     <= inb;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_W-2*COORD_BITS-1){1'b0}}, inb_q, src_row_q, src_col_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !inb_q |-> src_col_q == '0 && src_row_q == '0)
    else $error("out of bounds result carries nonzero coordinates");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while the pipe is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(s_q) && $stable(sc_q))
    else $error("pipeline stage moved during a stall");

endmodule

### sim/fov_lens_undistort_map_core_tb.sv
// testbench for the fov lens remap core: streams pixel coordinates and checks source coordinates
`timescale 1ns / 100ps

module fov_lens_undistort_map_core_tb;

  localparam int unsigned CB = 12;
  localparam int unsigned STEPS = 20;
  localparam int unsigned LATENCY = 65 + STEPS;

  typedef struct packed {
    logic          in_bounds;
    logic [CB-1:0] src_row;
    logic [CB-1:0] src_col;
  } remap_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // out_col, out_row
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // src_col, src_row, in_bounds
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [fovu_pkg::CFG_ADDR_W-1:0] cfg_addr_i;
  logic [fovu_pkg::CFG_DATA_W-1:0] cfg_data_i;

  fov_lens_undistort_map_core uut (.*);

  // own copy of the lens registers
  longint unsigned c_col, c_row, ifx, ify, ifov, ttan, n_cols, n_rows;

  remap_t expected_q[$];
  int     errors;
  int     n_checked;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     holdoff;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint signed fdiv_shift(longint signed v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned arctan_q16(longint unsigned t);
    longint signed x, y, z, xs, ys;
    x = 65536;
    y = longint'(t);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = fdiv_shift(x, i);
      ys = fdiv_shift(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(fovu_pkg::atan_tab(i));
      end else begin
        x -= ys; y += xs; z -= longint'(fovu_pkg::atan_tab(i));
      end
    end
    return (z < 0) ? 0 : longint'(z);
  endfunction

  function automatic longint signed scaled_offset(longint signed d, longint unsigned s);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    m = (m * s) >> 24;
    return (d < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic remap_t predict_source(logic [CB-1:0] u, logic [CB-1:0] v);
    longint signed dx, dy, sc, sr;
    longint unsigned ax, ay, x, y, r, s, t, rd, cols, rows;
    remap_t res;
    dx = longint'(u) * 256 - longint'(c_col);
    dy = longint'(v) * 256 - longint'(c_row);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    x = (ax * ifx) >> 16;
    if (x > 64'hFFFFF) x = 64'hFFFFF;
    y = (ay * ify) >> 16;
    if (y > 64'hFFFFF) y = 64'hFFFFF;
    r = int_sqrt(x * x + y * y);
    if (r == 0) begin
      s = (ttan * ifov) >> 8;
    end else begin
      t = (r * ttan) >> 16;
      rd = (arctan_q16(t) * ifov) >> 16;
      s = (rd << 24) / r;
    end
    if (s > 64'hFFFFFFFF) s = 64'hFFFFFFFF;
    cols = (n_cols > 4096) ? 4096 : n_cols;
    rows = (n_rows > 4096) ? 4096 : n_rows;
    sc = longint'(c_col) + scaled_offset(dx, s);
    sr = longint'(c_row) + scaled_offset(dy, s);
    res = '0;
    if (sc >= 0 && sr >= 0 && sc < longint'(cols << 8) && sr < longint'(rows << 8)) begin
      res.src_col = sc[CB+7:8];
      res.src_row = sr[CB+7:8];
      res.in_bounds = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic write_reg(logic [fovu_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fovu_pkg::REG_CENTER_COL:  c_col = val & 32'hFFFFF;
      fovu_pkg::REG_CENTER_ROW:  c_row = val & 32'hFFFFF;
      fovu_pkg::REG_INV_FOCAL_X: ifx = val & 32'h1FFFFFF;
      fovu_pkg::REG_INV_FOCAL_Y: ify = val & 32'h1FFFFFF;
      fovu_pkg::REG_INV_FOV:     ifov = val & 32'hFFFFF;
      fovu_pkg::REG_TWICE_TAN:   ttan = val & 32'h3FFFFF;
      fovu_pkg::REG_IMAGE_COLS:  n_cols = val & 32'h1FFF;
      fovu_pkg::REG_IMAGE_ROWS:  n_rows = val & 32'h1FFF;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [CB-1:0] col, logic [CB-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {row, col};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.insert(expected_q.size(), predict_source(col, row));
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_lens(longint unsigned cc, longint unsigned cr, longint unsigned fx,
                          longint unsigned fy, longint unsigned fv, longint unsigned tt,
                          longint unsigned nc, longint unsigned nr);
    write_reg(fovu_pkg::REG_CENTER_COL, cc);
    write_reg(fovu_pkg::REG_CENTER_ROW, cr);
    write_reg(fovu_pkg::REG_INV_FOCAL_X, fx);
    write_reg(fovu_pkg::REG_INV_FOCAL_Y, fy);
    write_reg(fovu_pkg::REG_INV_FOV, fv);
    write_reg(fovu_pkg::REG_TWICE_TAN, tt);
    write_reg(fovu_pkg::REG_IMAGE_COLS, nc);
    write_reg(fovu_pkg::REG_IMAGE_ROWS, nr);
  endtask

  task automatic test_directed;
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    send_pixel(320, 240);          // center pixel
    send_pixel(639, 479);
    send_pixel(640, 480);          // just outside
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();
    // zero reciprocals, zero image size, oversize image
    set_lens(0, 0, 0, 0, 20'hFFFFF, 22'h3FFFFF, 0, 0);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    set_lens(20'hFFFFF, 20'hFFFFF, 25'h1000000, 25'h1000000, 1, 0, 13'h1FFF, 4096);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 0);
    drain();
    write_reg(4'd9, 32'hFFFFFFFF);  // unused index
    set_lens(0, 0, 25'h1FFFFFF, 25'h1FFFFFF, 65536, 71608, 4096, 4096);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        drain();
        case ($urandom_range(3))
          0: set_lens($urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                      $urandom_range(25'h1FFFFFF), $urandom_range(25'h1FFFFFF),
                      $urandom_range(20'hFFFFF), $urandom_range(22'h3FFFFF),
                      $urandom_range(13'h1FFF), $urandom_range(13'h1FFF));
          default: set_lens($urandom_range(1048575), $urandom_range(1048575),
                            $urandom_range(1 << 17, 1), $urandom_range(1 << 17, 1),
                            $urandom_range(131072, 32768), $urandom_range(200000, 30000),
                            $urandom_range(4096, 1), $urandom_range(4096, 1));
        endcase
      end
      send_pixel($urandom_range(12'hFFF), $urandom_range(12'hFFF));
    end
    drain();
  endtask

  task automatic test_backpressure;
    holdoff = 300;
    send_idle_pct = 0;
    for (int i = 0; i < 200; i++) send_pixel($urandom_range(12'hFFF), $urandom_range(12'hFFF));
    drain();
  endtask

  // receiver ready, with an optional long hold-off
  always @(posedge clk_i) begin
    if (holdoff > 0) begin
      holdoff <= holdoff - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    remap_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[2*CB:0];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", got, 0);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got.src_col !== want.src_col) report_mismatch("src_col", got.src_col, want.src_col);
        if (got.src_row !== want.src_row) report_mismatch("src_row", got.src_row, want.src_row);
        if (got.in_bounds !== want.in_bounds)
          report_mismatch("in_bounds", got.in_bounds, want.in_bounds);
      end
    end
  end

  initial begin
    errors = 0;
    n_checked = 0;
    holdoff = 0;
    send_idle_pct = 18;
    recv_idle_pct = 64;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    c_col = 81920; c_row = 61440; ifx = 65536; ify = 65536;
    ifov = 65536; ttan = 71608; n_cols = 640; n_rows = 480;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    send_idle_pct = 64;
    recv_idle_pct = 18;
    test_random(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);
    test_backpressure();
    $display("covered extremes, center and zero-size cases, %0d results checked", n_checked);
    $display("random lens settings under sender and receiver stalls with a long hold-off");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
